[sv/pfe_pkg.sv]
// pfe_pkg: shared types, letter constants and square helpers for the playfair encryptor
// depends on: nothing
`timescale 1ns / 1ps

package pfe_pkg;

   // letter index a=0..z=25 and cell index 0..24 in the 5x5 square
   typedef logic [4:0] letter_type;
   typedef logic [4:0] cell_type;
   typedef logic [2:0] coord_type;
   typedef logic [1:0] op_type;

   // op codes of the request word
   localparam op_type OpKeyLetter = 2'd0;
   localparam op_type OpKeyDone   = 2'd1;
   localparam op_type OpPlain     = 2'd2;
   localparam op_type OpFlush     = 2'd3;

   // letter constants
   localparam letter_type LetA     = 5'd0;
   localparam letter_type LetI     = 5'd8;
   localparam letter_type LetJ     = 5'd9;
   localparam letter_type LetX     = 5'd23;
   localparam letter_type LetZ     = 5'd25;
   localparam int         AlphaLen = 26;
   localparam int         SqCells  = 25;
   localparam int         SqSide   = 5;

   localparam coord_type LastCoord = 3'(SqSide - 1);

   // row of a cell, by compare chain instead of a divide
   function automatic coord_type cell_row(input cell_type pos);
      coord_type row;
      if (pos >= 5'd20) row = 3'd4;
      else if (pos >= 5'd15) row = 3'd3;
      else if (pos >= 5'd10) row = 3'd2;
      else if (pos >= 5'd5) row = 3'd1;
      else row = 3'd0;
      return row;
   endfunction

   // column of a cell: cell minus row*5
   function automatic coord_type cell_col(input cell_type pos);
      coord_type row;
      cell_type  rem;
      row = cell_row(pos);
      rem = pos - {row, 2'b00} - {2'b00, row};
      return rem[2:0];
   endfunction

   // cell index from row and column
   function automatic cell_type cell_index(input coord_type row, input coord_type col);
      return {row, 2'b00} + {2'b00, row} + {2'b00, col};
   endfunction

   // next coordinate with wrap around
   function automatic coord_type coord_next(input coord_type c);
      return (c == LastCoord) ? 3'd0 : c + 3'd1;
   endfunction

   // filler letter: x, or z when the letter itself is x
   function automatic letter_type filler_for(input letter_type let_in);
      return (let_in == LetX) ? LetZ : LetX;
   endfunction

endpackage

[sv/pfe_req_if.sv]
// pfe_req_if: request channel carrying one op/letter word with valid/ready
// depends on: pfe_pkg
`timescale 1ns / 1ps

interface pfe_req_if;
   logic               valid;
   logic               ready;
   pfe_pkg::op_type    op;
   pfe_pkg::letter_type letter;

   modport source (output valid, output op, output letter, input ready);
   modport sink   (input valid, input op, input letter, output ready);
endinterface

[sv/pfe_rsp_if.sv]
// pfe_rsp_if: response channel carrying one enciphered pair with valid/ready
// depends on: pfe_pkg
`timescale 1ns / 1ps

interface pfe_rsp_if;
   logic                valid;
   logic                ready;
   pfe_pkg::letter_type first_cipher;
   pfe_pkg::letter_type second_cipher;
   logic                last_of_message;

   modport source (output valid, output first_cipher, output second_cipher,
                   output last_of_message, input ready);
   modport sink   (input valid, input first_cipher, input second_cipher,
                   input last_of_message, output ready);
endinterface

[sv/playfair_cipher_encrypt.sv]
// playfair_cipher_encrypt: top level of the playfair encryptor
// depends on: pfe_pkg, pfe_req_if, pfe_rsp_if, pfe_ram
`timescale 1ns / 1ps

// Playfair encryptor over letters 0..25 (j read as i). Key letters, a key-done word,
// plaintext letters and a flush word arrive on req_chan; each finished pair leaves on
// rsp_chan as two cipher letters plus a flag set when the flush closed the message.
// A key letter, an ignored word and a plaintext letter that only waits for its partner
// leave the block idle and ready. A key-done word walks the alphabet one letter a cycle.
// A word that completes a pair steps through StPosA, StPosB, StSqA, StSqB and StDone: the
// square and the letter-position table each have a single read port, so the two position
// lookups and the two square reads are done one after the other. The next word is taken
// once the pair is in the output register, which holds it until rsp_chan takes it.
module playfair_cipher_encrypt (
   input  logic     clock,
   input  logic     reset,
   pfe_req_if.sink  req_chan,
   pfe_rsp_if.source rsp_chan
);

   // sequencer states
   localparam logic [2:0] StIdle = 3'd0;
   localparam logic [2:0] StFill = 3'd1;
   localparam logic [2:0] StPosA = 3'd2;
   localparam logic [2:0] StPosB = 3'd3;
   localparam logic [2:0] StSqA  = 3'd4;
   localparam logic [2:0] StSqB  = 3'd5;
   localparam logic [2:0] StDone = 3'd6;

   logic [2:0]          state_ff, state_in;
   pfe_pkg::letter_type walk_ff, walk_in;
   pfe_pkg::cell_type   fill_ff, fill_in;
   logic                sq_ready_ff, sq_ready_in;
   logic [25:0]         present_ff, present_in;
   logic                pend_valid_ff, pend_valid_in;
   pfe_pkg::letter_type pend_ff, pend_in;
   pfe_pkg::letter_type a_ff, a_in;
   pfe_pkg::letter_type b_ff, b_in;
   logic                last_ff, last_in;
   pfe_pkg::cell_type   pa_ff, pa_in;
   pfe_pkg::cell_type   cb_ff, cb_in;
   pfe_pkg::letter_type first_ff, first_in;
   logic                rsp_valid_ff, rsp_valid_in;
   pfe_pkg::letter_type rsp_first_ff, rsp_first_in;
   pfe_pkg::letter_type rsp_second_ff, rsp_second_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                accept;
   pfe_pkg::letter_type let_fold;
   logic                let_ok;
   logic                place_req;
   logic                place_en;
   pfe_pkg::letter_type place_let;
   pfe_pkg::letter_type pos_raddr;
   pfe_pkg::cell_type   pos_rdata;
   pfe_pkg::cell_type   sq_raddr;
   pfe_pkg::letter_type sq_rdata;
   pfe_pkg::coord_type  r1, c1, r2, c2;
   pfe_pkg::cell_type   ca, cb;

   assign req_chan.ready = (state_ff == StIdle);
   assign accept         = req_chan.valid && req_chan.ready;

   // fold j to i and range check
   assign let_ok   = (req_chan.letter < 5'(pfe_pkg::AlphaLen));
   assign let_fold = (req_chan.letter == pfe_pkg::LetJ) ? pfe_pkg::LetI : req_chan.letter;

   // position of each placed letter
   pfe_ram #(.WIDTH(5), .DEPTH(26)) u_pos_ram (
      .clock   (clock),
      .wr_en   (place_en),
      .wr_addr (place_let),
      .wr_data (fill_ff),
      .rd_addr (pos_raddr),
      .rd_data (pos_rdata)
   );

   // square cells, row-major
   pfe_ram #(.WIDTH(5), .DEPTH(25)) u_sq_ram (
      .clock   (clock),
      .wr_en   (place_en),
      .wr_addr (fill_ff),
      .wr_data (place_let),
      .rd_addr (sq_raddr),
      .rd_data (sq_rdata)
   );

   // letter placement shared by key letters and the alphabet walk
   always_comb begin
      place_let = (state_ff == StFill) ? walk_ff : let_fold;
      place_req = 1'b0;
      if (state_ff == StFill) begin
         place_req = (walk_ff != pfe_pkg::LetJ);
      end else if (accept && req_chan.op == pfe_pkg::OpKeyLetter) begin
         place_req = let_ok && !sq_ready_ff;
      end
      place_en = place_req && !present_ff[place_let]
                 && (fill_ff < 5'(pfe_pkg::SqCells));
   end

   // rectangle, row and column rules on the two looked-up positions
   always_comb begin
      r1 = pfe_pkg::cell_row(pa_ff);
      c1 = pfe_pkg::cell_col(pa_ff);
      r2 = pfe_pkg::cell_row(pos_rdata);
      c2 = pfe_pkg::cell_col(pos_rdata);
      if (r1 == r2) begin
         ca = pfe_pkg::cell_index(r1, pfe_pkg::coord_next(c1));
         cb = pfe_pkg::cell_index(r2, pfe_pkg::coord_next(c2));
      end else if (c1 == c2) begin
         ca = pfe_pkg::cell_index(pfe_pkg::coord_next(r1), c1);
         cb = pfe_pkg::cell_index(pfe_pkg::coord_next(r2), c2);
      end else begin
         ca = pfe_pkg::cell_index(r1, c2);
         cb = pfe_pkg::cell_index(r2, c1);
      end
   end

   // sequencer and next-state logic
   always_comb begin
      state_in      = state_ff;
      walk_in       = walk_ff;
      fill_in       = fill_ff;
      sq_ready_in   = sq_ready_ff;
      present_in    = present_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      last_in       = last_ff;
      pa_in         = pa_ff;
      cb_in         = cb_ff;
      first_in      = first_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_first_in  = rsp_first_ff;
      rsp_second_in = rsp_second_ff;
      rsp_last_in   = rsp_last_ff;
      pos_raddr     = a_ff;
      sq_raddr      = cb_ff;

      if (place_en) begin
         present_in[place_let] = 1'b1;
         fill_in               = fill_ff + 5'd1;
      end

      unique case (state_ff)
         StIdle: begin
            if (accept) begin
               unique case (req_chan.op)
                  pfe_pkg::OpKeyLetter: begin
                  end
                  pfe_pkg::OpKeyDone: begin
                     if (!sq_ready_ff) begin
                        walk_in  = pfe_pkg::LetA;
                        state_in = StFill;
                     end
                  end
                  pfe_pkg::OpFlush: begin
                     if (sq_ready_ff && pend_valid_ff) begin
                        a_in          = pend_ff;
                        b_in          = pfe_pkg::filler_for(pend_ff);
                        last_in       = 1'b1;
                        pend_valid_in = 1'b0;
                        state_in      = StPosA;
                     end
                  end
                  pfe_pkg::OpPlain: begin
                     if (let_ok && sq_ready_ff) begin
                        if (!pend_valid_ff) begin
                           pend_in       = let_fold;
                           pend_valid_in = 1'b1;
                        end else if (pend_ff == let_fold) begin
                           // doubled letter: filler closes the pair, letter stays pending
                           a_in     = pend_ff;
                           b_in     = pfe_pkg::filler_for(pend_ff);
                           last_in  = 1'b0;
                           state_in = StPosA;
                        end else begin
                           a_in          = pend_ff;
                           b_in          = let_fold;
                           last_in       = 1'b0;
                           pend_valid_in = 1'b0;
                           state_in      = StPosA;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         StFill: begin
            walk_in = walk_ff + 5'd1;
            if (walk_ff == 5'(pfe_pkg::AlphaLen - 1)) begin
               sq_ready_in = 1'b1;
               state_in    = StIdle;
            end
         end
         StPosA: begin
            pos_raddr = a_ff;
            state_in  = StPosB;
         end
         StPosB: begin
            pos_raddr = b_ff;
            pa_in     = pos_rdata;
            state_in  = StSqA;
         end
         StSqA: begin
            sq_raddr = ca;
            cb_in    = cb;
            state_in = StSqB;
         end
         StSqB: begin
            sq_raddr = cb_ff;
            first_in = sq_rdata;
            state_in = StDone;
         end
         StDone: begin
            // hold the read address so the second letter stays on the ram output
            sq_raddr = cb_ff;
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_first_in  = first_ff;
               rsp_second_in = sq_rdata;
               rsp_last_in   = last_ff;
               state_in      = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= StIdle;
         fill_ff       <= '0;
         sq_ready_ff   <= 1'b0;
         present_ff    <= '0;
         pend_valid_ff <= 1'b0;
         pend_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         sq_ready_ff   <= sq_ready_in;
         present_ff    <= present_in;
         pend_valid_ff <= pend_valid_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      walk_ff       <= walk_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      last_ff       <= last_in;
      pa_ff         <= pa_in;
      cb_ff         <= cb_in;
      first_ff      <= first_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // output word
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.first_cipher    = rsp_first_ff;
   assign rsp_chan.second_cipher   = rsp_second_ff;
   assign rsp_chan.last_of_message = rsp_last_ff;

endmodule

[sv/pfe_ram.sv]
// pfe_ram: generic single write, single read ram with registered read data
// depends on: nothing
`timescale 1ns / 1ps

module pfe_ram #(
   parameter int WIDTH = 5,
   parameter int DEPTH = 26
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[dv/tb.sv]
// tb: self-checking testbench for playfair_cipher_encrypt, key setup then random plaintext
// depends on: pfe_pkg, pfe_req_if, pfe_rsp_if and the playfair_cipher_encrypt rtl
`timescale 1ns / 1ps

module tb;

   // one request word as queued for the driver
   typedef struct {
      pfe_pkg::op_type     op;
      pfe_pkg::letter_type letter;
      int                  gap;
      bit                  drain;
   } req_word_type;

   // one enciphered pair
   typedef struct packed {
      pfe_pkg::letter_type first;
      pfe_pkg::letter_type second;
      logic                last;
   } cipher_pair_type;

   logic clock = 1'b0;
   logic reset;

   pfe_req_if req_if ();
   pfe_rsp_if rsp_if ();

   playfair_cipher_encrypt u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // predicted square and pairing state
   pfe_pkg::letter_type square_cell [pfe_pkg::SqCells];
   pfe_pkg::cell_type   cell_of [pfe_pkg::AlphaLen];
   bit                  placed [pfe_pkg::AlphaLen];
   int                  filled;
   bit                  key_closed;
   bit                  held_valid;
   pfe_pkg::letter_type held_letter;

   req_word_type    pending_words [$];
   cipher_pair_type expected_pairs [$];

   int gap_left;
   int stall_left;
   int hold_left;
   bit hold_done;
   int pairs_seen;
   int mismatches;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // idle length: mostly short, a few long
   function automatic int pick_idle();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      else if (roll < 85) return $urandom_range(1, 3);
      else if (roll < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   function automatic pfe_pkg::letter_type pad_letter(pfe_pkg::letter_type l);
      return (l == pfe_pkg::LetX) ? pfe_pkg::LetZ : pfe_pkg::LetX;
   endfunction

   // append a letter to the square unless it is already there
   function automatic void place_key_letter(pfe_pkg::letter_type l);
      if (placed[l] || filled >= pfe_pkg::SqCells) return;
      square_cell[filled] = l;
      cell_of[l] = pfe_pkg::cell_type'(filled);
      placed[l] = 1'b1;
      filled++;
   endfunction

   // playfair rules on two square positions
   function automatic cipher_pair_type cipher_pair(pfe_pkg::letter_type a,
                                                   pfe_pkg::letter_type b, logic last);
      int pa, pb, ra, ca, rb, cb, oa, ob;
      cipher_pair_type p;
      pa = cell_of[a];
      pb = cell_of[b];
      ra = pa / pfe_pkg::SqSide;
      ca = pa % pfe_pkg::SqSide;
      rb = pb / pfe_pkg::SqSide;
      cb = pb % pfe_pkg::SqSide;
      if (ra == rb) begin
         oa = ra * pfe_pkg::SqSide + (ca + 1) % pfe_pkg::SqSide;
         ob = rb * pfe_pkg::SqSide + (cb + 1) % pfe_pkg::SqSide;
      end else if (ca == cb) begin
         oa = ((ra + 1) % pfe_pkg::SqSide) * pfe_pkg::SqSide + ca;
         ob = ((rb + 1) % pfe_pkg::SqSide) * pfe_pkg::SqSide + cb;
      end else begin
         oa = ra * pfe_pkg::SqSide + cb;
         ob = rb * pfe_pkg::SqSide + ca;
      end
      p.first  = square_cell[oa];
      p.second = square_cell[ob];
      p.last   = last;
      return p;
   endfunction

   // update predicted state for one accepted word, queue any pair it completes
   function automatic void predict_word(pfe_pkg::op_type op, pfe_pkg::letter_type raw);
      pfe_pkg::letter_type l;
      if (op == pfe_pkg::OpKeyDone) begin
         if (!key_closed) begin
            for (int c = 0; c < pfe_pkg::AlphaLen; c++)
               if (c != pfe_pkg::LetJ) place_key_letter(pfe_pkg::letter_type'(c));
            key_closed = 1'b1;
         end
         return;
      end
      if (op == pfe_pkg::OpFlush) begin
         if (key_closed && held_valid) begin
            expected_pairs.push_back(cipher_pair(held_letter, pad_letter(held_letter),
                                                 1'b1));
            held_valid = 1'b0;
         end
         return;
      end
      if (raw >= pfe_pkg::AlphaLen) return;
      l = (raw == pfe_pkg::LetJ) ? pfe_pkg::LetI : raw;
      if (op == pfe_pkg::OpKeyLetter) begin
         if (!key_closed) place_key_letter(l);
         return;
      end
      if (!key_closed) return;
      if (!held_valid) begin
         held_letter = l;
         held_valid  = 1'b1;
      end else if (held_letter == l) begin
         // doubled letter: pad, the repeat opens the next pair
         expected_pairs.push_back(cipher_pair(l, pad_letter(l), 1'b0));
      end else begin
         expected_pairs.push_back(cipher_pair(held_letter, l, 1'b0));
         held_valid = 1'b0;
      end
   endfunction

   task automatic queue_word(pfe_pkg::op_type op, pfe_pkg::letter_type letter, bit calm,
                             bit drain);
      req_word_type w;
      w.op     = op;
      w.letter = letter;
      w.gap    = calm ? 0 : pick_idle();
      w.drain  = drain;
      pending_words.push_back(w);
   endtask

   // request driver
   always @(posedge clock) begin : driver
      req_word_type w;
      if (reset) begin
         req_if.valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_if.valid && req_if.ready) predict_word(req_if.op, req_if.letter);
         if (!req_if.valid || req_if.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_if.valid <= 1'b0;
            end else if (pending_words.size() != 0 &&
                         !(pending_words[0].drain && expected_pairs.size() != 0)) begin
               w = pending_words.pop_front();
               req_if.valid  <= 1'b1;
               req_if.op     <= w.op;
               req_if.letter <= w.letter;
               gap_left = w.gap;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and checker
   always @(posedge clock) begin : monitor
      cipher_pair_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
         hold_left  = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_pairs.size() == 0) begin
               $error("unexpected pair first_cipher %0d second_cipher %0d last_of_message %0d",
                      rsp_if.first_cipher, rsp_if.second_cipher, rsp_if.last_of_message);
               mismatches++;
            end else begin
               want = expected_pairs.pop_front();
               if (rsp_if.first_cipher !== want.first) begin
                  $error("first_cipher expected %0d actual %0d", want.first,
                         rsp_if.first_cipher);
                  mismatches++;
               end
               if (rsp_if.second_cipher !== want.second) begin
                  $error("second_cipher expected %0d actual %0d", want.second,
                         rsp_if.second_cipher);
                  mismatches++;
               end
               if (rsp_if.last_of_message !== want.last) begin
                  $error("last_of_message expected %0d actual %0d", want.last,
                         rsp_if.last_of_message);
                  mismatches++;
               end
            end
            pairs_seen++;
         end
         // one long hold-off so the block backs up into its input
         if (!hold_done && pairs_seen >= 250) begin
            hold_done = 1'b1;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            stall_left = ((pairs_seen / 120) % 3 == 2) ? 0 : pick_idle();
         end
      end
   end

   // stimulus and end of run
   initial begin : stimulus
      int                  useful;
      int                  roll;
      int                  next_drain;
      bit                  calm;
      bit                  drain;
      pfe_pkg::letter_type prev;
      pfe_pkg::letter_type l;

      reset         = 1'b1;
      req_if.valid  = 1'b0;
      req_if.op     = pfe_pkg::OpKeyLetter;
      req_if.letter = pfe_pkg::LetA;
      rsp_if.ready  = 1'b0;

      // before the key is closed: plaintext and flush do nothing
      queue_word(pfe_pkg::OpPlain,     5'd3,           1'b0, 1'b0);
      queue_word(pfe_pkg::OpFlush,     5'd31,          1'b0, 1'b0);
      // key letters p l a y f a j i x z, with a repeat, j folded to i and a bad letter
      queue_word(pfe_pkg::OpKeyLetter, 5'd15,          1'b0, 1'b0);
      queue_word(pfe_pkg::OpKeyLetter, 5'd11,          1'b0, 1'b0);
      queue_word(pfe_pkg::OpKeyLetter, pfe_pkg::LetA,  1'b0, 1'b0);
      queue_word(pfe_pkg::OpKeyLetter, 5'd24,          1'b0, 1'b0);
      queue_word(pfe_pkg::OpKeyLetter, 5'd5,           1'b0, 1'b0);
      queue_word(pfe_pkg::OpKeyLetter, pfe_pkg::LetA,  1'b0, 1'b0);
      queue_word(pfe_pkg::OpKeyLetter, pfe_pkg::LetJ,  1'b0, 1'b0);
      queue_word(pfe_pkg::OpKeyLetter, pfe_pkg::LetI,  1'b0, 1'b0);
      queue_word(pfe_pkg::OpKeyLetter, 5'd31,          1'b0, 1'b0);
      queue_word(pfe_pkg::OpKeyLetter, pfe_pkg::LetX,  1'b0, 1'b0);
      queue_word(pfe_pkg::OpKeyLetter, pfe_pkg::LetZ,  1'b0, 1'b0);
      queue_word(pfe_pkg::OpKeyDone,   5'd31,          1'b0, 1'b0);
      // repeated key done and late key letter are ignored
      queue_word(pfe_pkg::OpKeyDone,   pfe_pkg::LetA,  1'b0, 1'b0);
      queue_word(pfe_pkg::OpKeyLetter, 5'd1,           1'b0, 1'b0);
      // out of range plaintext, doubled letters, x padded with z, flush
      queue_word(pfe_pkg::OpPlain,     5'd31,          1'b0, 1'b0);
      queue_word(pfe_pkg::OpPlain,     5'd26,          1'b0, 1'b0);
      queue_word(pfe_pkg::OpPlain,     pfe_pkg::LetA,  1'b0, 1'b0);
      queue_word(pfe_pkg::OpPlain,     pfe_pkg::LetA,  1'b0, 1'b0);
      queue_word(pfe_pkg::OpPlain,     pfe_pkg::LetZ,  1'b0, 1'b0);
      queue_word(pfe_pkg::OpPlain,     pfe_pkg::LetX,  1'b0, 1'b0);
      queue_word(pfe_pkg::OpPlain,     pfe_pkg::LetX,  1'b0, 1'b0);
      queue_word(pfe_pkg::OpFlush,     pfe_pkg::LetA,  1'b0, 1'b0);
      queue_word(pfe_pkg::OpFlush,     pfe_pkg::LetA,  1'b0, 1'b0);
      queue_word(pfe_pkg::OpPlain,     pfe_pkg::LetJ,  1'b0, 1'b0);
      queue_word(pfe_pkg::OpPlain,     pfe_pkg::LetI,  1'b0, 1'b0);
      queue_word(pfe_pkg::OpPlain,     5'd4,           1'b0, 1'b0);

      // random plaintext stream with a little noise
      useful     = 0;
      next_drain = 600;
      prev       = pfe_pkg::LetA;
      while (pending_words.size() < 1850) begin
         calm  = ((useful / 150) % 3) == 1;
         drain = 1'b0;
         if (useful >= next_drain) begin
            drain = 1'b1;
            next_drain += 800;
         end
         roll = $urandom_range(0, 99);
         if (roll < 75) begin
            if ($urandom_range(0, 99) < 20) l = prev;
            else l = pfe_pkg::letter_type'($urandom_range(0, 25));
            queue_word(pfe_pkg::OpPlain, l, calm, drain);
            prev = l;
            useful++;
         end else if (roll < 82) begin
            queue_word(pfe_pkg::OpFlush, pfe_pkg::letter_type'($urandom_range(0, 31)),
                       calm, drain);
            useful++;
         end else if (roll < 88) begin
            queue_word(pfe_pkg::OpPlain, pfe_pkg::letter_type'($urandom_range(26, 31)),
                       calm, drain);
         end else if (roll < 93) begin
            queue_word(pfe_pkg::OpKeyLetter, pfe_pkg::letter_type'($urandom_range(0, 31)),
                       calm, drain);
         end else if (roll < 96) begin
            queue_word(pfe_pkg::OpKeyDone, pfe_pkg::letter_type'($urandom_range(0, 31)),
                       calm, drain);
         end else begin
            queue_word(pfe_pkg::OpPlain, pfe_pkg::LetJ, calm, drain);
            useful++;
         end
      end
      queue_word(pfe_pkg::OpFlush, pfe_pkg::LetA, 1'b0, 1'b0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // wait for all words taken, then all pairs back, then let the block settle
      while (pending_words.size() != 0 || req_if.valid) @(negedge clock);
      while (expected_pairs.size() != 0) @(negedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0 && expected_pairs.size() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

   // timeout
   initial begin
      #20_000_000;
      $display("tb: done, errors");
      $finish;
   end

endmodule
